// ----- rtl/core/rgv_pkg.sv -----
// Shared types and constants for the ReplayGain volume calculator.
// No dependencies; used by rgv_peak_div and replay_gain_volume_calc.
package rgv_pkg;

  // Default number of fraction bits in the volume result
  localparam int VOLUME_FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_MODE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREAMP    = 4'd1;

  // Volume limits: VOL_OVER marks any value above the 24-bit maximum
  localparam logic [24:0] VOL_MAX  = 25'h0FF_FFFF;
  localparam logic [24:0] VOL_OVER = 25'h100_0000;

  // log2(10)/20 in Q24, ln2 in Q32, one in Q32
  localparam logic [21:0] LOG2_10_OVER_20_Q24 = 22'd2786635;
  localparam logic [31:0] LN2_Q32             = 32'hB172_17F8;
  localparam logic [32:0] ONE_Q32             = 33'h1_0000_0000;

  // floor(2^38 / 100) for the final divide by one hundred
  localparam logic [31:0] RECIP_100_Q38 = 32'd2748779069;
  localparam int          RECIP_TERM_SH = 35;

  localparam int          TAYLOR_TERMS = 12;
  localparam logic [15:0] PEAK_ONE     = 16'd4096;
  localparam logic [9:0]  PREAMP_UNITY = 10'd100;

  typedef enum logic [2:0] {
    MODE_UNITY      = 3'd0,
    MODE_ALBUM_GAIN = 3'd1,
    MODE_ALBUM_PEAK = 3'd2,
    MODE_TRACK_GAIN = 3'd3,
    MODE_TRACK_PEAK = 3'd4,
    MODE_ALBUM_CLIP = 3'd5,
    MODE_TRACK_CLIP = 3'd6
  } mode_t;

  // What the final stage picks
  typedef enum logic [1:0] {
    KIND_UNITY,
    KIND_GAIN,
    KIND_PEAK,
    KIND_MIN
  } kind_t;

  // Sideband that travels with each item down the pipeline
  typedef struct packed {
    logic               found;
    kind_t              kind;
    logic [9:0]         pre;
    logic signed [5:0]  ip;
    logic [24:0]        peak_v;
  } side_t;

endpackage

// ----- rtl/core/replay_gain_volume_calc.sv -----
// ReplayGain volume calculator: one gain record in, one Q8.16 volume factor out.
// Depends on rgv_pkg and rgv_peak_div.
//
// The block takes one item per clock while input is not held off by the skid
// entry. The pipeline holds the exponent series (12 terms, three register
// stages each: multiply, reciprocal multiply, correct-and-accumulate) plus the
// decode, exponent, ln2, preamp, power-of-two, divide-by-100 and select stages;
// the peak divider runs alongside, one quotient bit per stage. An output
// register and one skid entry sit behind the pipeline: when the sink stalls a
// waiting result and a second result arrives behind it, the skid entry takes
// that result and input is held off from the next cycle until the sink takes an
// item and the skid entry has moved into the output register. Configuration
// writes are always taken (cfg_ready high) and apply to items accepted
// afterwards. Items with no field present give unity.
module replay_gain_volume_calc #(
  parameter int VOLUME_FRAC_BITS = rgv_pkg::VOLUME_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rgv_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // album_gain_db[15:0], track_gain_db[31:16], album_peak_level[47:32],
  // track_peak_level[63:48]
  input  logic [63:0]                      s_tdata,
  // album_gain_present[0], track_gain_present[1], album_peak_present[2],
  // track_peak_present[3]
  input  logic [3:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // volume[23:0]
  output logic [23:0]                      m_tdata,
  // found[0], saturated[1]
  output logic [1:0]                       m_tuser
);
  import rgv_pkg::*;

  // Stage map
  localparam int ST_E     = 1;
  localparam int ST_Y     = 2;
  localparam int ST_T0    = 3;
  localparam int ST_T     = ST_T0 + 3 * TAYLOR_TERMS;
  localparam int ST_X     = ST_T + 1;
  localparam int ST_Q     = ST_X + 1;
  localparam int ST_G     = ST_Q + 1;
  localparam int ST_F     = ST_G + 1;
  localparam int DEPTH    = ST_F + 1;
  localparam int PK_STAGE = VOLUME_FRAC_BITS + 14;

  // Configuration registers
  logic [2:0] gain_mode;
  logic [9:0] preamp_percent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode      <= '0;
      preamp_percent <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_GAIN_MODE) begin
        gain_mode <= cfg_data[2:0];
      end else if (cfg_index == CFG_PREAMP) begin
        preamp_percent <= cfg_data;
      end
    end
  end

  // Pipeline control
  logic             en;
  logic [DEPTH-1:0] v;
  logic             out_v;
  logic             skid_v;

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 0: fill in missing fields, pick gain and peak per mode
  logic [15:0] ag_r, tg_r, ap_r, tp_r;
  logic        found_d, trk;
  kind_t       kind_d;

  always_comb begin
    ag_r = s_tuser[0] ? s_tdata[15:0] : (s_tuser[1] ? s_tdata[31:16] : 16'd0);
    tg_r = s_tuser[1] ? s_tdata[31:16] : ag_r;
    ap_r = s_tuser[2] ? s_tdata[47:32] : (s_tuser[3] ? s_tdata[63:48] : PEAK_ONE);
    tp_r = s_tuser[3] ? s_tdata[63:48] : ap_r;
    found_d = |s_tuser;
    unique case (mode_t'(gain_mode))
      MODE_ALBUM_GAIN: begin kind_d = KIND_GAIN;  trk = 1'b0; end
      MODE_ALBUM_PEAK: begin kind_d = KIND_PEAK;  trk = 1'b0; end
      MODE_TRACK_GAIN: begin kind_d = KIND_GAIN;  trk = 1'b1; end
      MODE_TRACK_PEAK: begin kind_d = KIND_PEAK;  trk = 1'b1; end
      MODE_ALBUM_CLIP: begin kind_d = KIND_MIN;   trk = 1'b0; end
      MODE_TRACK_CLIP: begin kind_d = KIND_MIN;   trk = 1'b1; end
      default:         begin kind_d = KIND_UNITY; trk = 1'b0; end
    endcase
    if (!found_d) begin
      kind_d = KIND_UNITY;
    end
  end

  logic signed [15:0] g0;
  logic [15:0]        p0;
  logic signed [37:0] e1;
  side_t              sd    [0:ST_F-1];
  side_t              sd_nx [1:ST_F-1];

  always_ff @(posedge clk) begin
    if (en) begin
      g0 <= trk ? tg_r : ag_r;
      p0 <= trk ? tp_r : ap_r;
    end
  end

  // Peak path runs beside the gain path
  logic [24:0] pk_vol;

  rgv_peak_div #(
    .FRAC_BITS (VOLUME_FRAC_BITS)
  ) u_peak_div (
    .clk  (clk),
    .en   (en),
    .peak (p0),
    .vol  (pk_vol)
  );

  // Sideband shift, with the exponent integer and the peak result merged in
  always_comb begin
    for (int i = 1; i < ST_F; i++) begin
      sd_nx[i] = sd[i-1];
      if (i == ST_Y) begin
        sd_nx[i].ip = e1[37:32];
      end
      if (i == PK_STAGE) begin
        sd_nx[i].peak_v = pk_vol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0].found  <= found_d;
      sd[0].kind   <= kind_d;
      sd[0].pre    <= (preamp_percent == 10'd0) ? PREAMP_UNITY : preamp_percent;
      sd[0].ip     <= '0;
      sd[0].peak_v <= '0;
      for (int i = 1; i < ST_F; i++) begin
        sd[i] <= sd_nx[i];
      end
    end
  end

  // Stage 1: log2 of the factor in Q32
  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= 38'(g0) * $signed(38'(LOG2_10_OVER_20_Q24));
    end
  end

  // Stage 2: fraction times ln2
  logic [63:0] ymul;
  logic [31:0] y2;

  assign ymul = 64'(e1[31:0]) * 64'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      y2 <= ymul[63:32];
    end
  end

  // Exponent series, three stages per term
  logic [31:0] pa [0:TAYLOR_TERMS-1];
  logic [31:0] pb [0:TAYLOR_TERMS-1];
  logic [31:0] qb [0:TAYLOR_TERMS-1];
  logic [31:0] tc [0:TAYLOR_TERMS-1];
  logic [31:0] ya [0:TAYLOR_TERMS-1];
  logic [31:0] yb [0:TAYLOR_TERMS-1];
  logic [31:0] yc [0:TAYLOR_TERMS-1];
  logic [32:0] sa [0:TAYLOR_TERMS-1];
  logic [32:0] sb [0:TAYLOR_TERMS-1];
  logic [32:0] sc [0:TAYLOR_TERMS-1];

  for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_term
    localparam int          N_DIV = j + 1;
    localparam logic [35:0] RECIP = 36'((64'd1 << RECIP_TERM_SH) / N_DIV);

    logic [32:0] tin;
    logic [31:0] yin;
    logic [32:0] sin;
    logic [64:0] pmul;
    logic [67:0] qmul;
    logic [35:0] rr;
    logic [31:0] qv;

    if (j == 0) begin : g_first
      assign tin = ONE_Q32;
      assign yin = y2;
      assign sin = ONE_Q32;
    end else begin : g_next
      assign tin = {1'b0, tc[j-1]};
      assign yin = yc[j-1];
      assign sin = sc[j-1];
    end

    assign pmul = 65'(tin) * 65'(yin);
    assign qmul = 68'(pa[j]) * 68'(RECIP);
    // Reciprocal estimate is low by at most one
    assign rr   = 36'(pb[j]) - 36'(qb[j]) * 36'(N_DIV);
    assign qv   = qb[j] + 32'(rr >= 36'(N_DIV));

    always_ff @(posedge clk) begin
      if (en) begin
        pa[j] <= pmul[63:32];
        ya[j] <= yin;
        sa[j] <= sin;
        qb[j] <= qmul[66:35];
        pb[j] <= pa[j];
        yb[j] <= ya[j];
        sb[j] <= sa[j];
        tc[j] <= qv;
        yc[j] <= yb[j];
        sc[j] <= sb[j] + 33'(qv);
      end
    end
  end

  // Stage ST_T: mantissa times preamp
  logic [42:0] t39;

  always_ff @(posedge clk) begin
    if (en) begin
      t39 <= 43'(sc[TAYLOR_TERMS-1]) * 43'(sd[ST_T-1].pre);
    end
  end

  // Stage ST_X: apply the power of two, fold in the rounding half
  logic signed [7:0] sh;
  logic [7:0]        nsh;
  logic [63:0]       xs;
  logic              ov_x;
  logic [31:0]       xa40, xa41;
  logic              ov40, ov41;

  always_comb begin
    sh   = {{2{sd[ST_T].ip[5]}}, sd[ST_T].ip} + 8'(VOLUME_FRAC_BITS) - 8'd32;
    nsh  = 8'(-sh);
    xs   = '0;
    ov_x = 1'b0;
    if (sh > 8'sd20) begin
      ov_x = 1'b1;
    end else if (sh >= 8'sd0) begin
      xs   = 64'(t39) << sh[4:0];
      ov_x = |xs[63:31];
    end else begin
      xs   = (nsh > 8'd63) ? 64'd0 : (64'(t39) >> nsh[5:0]);
      ov_x = |xs[63:31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa40 <= {1'b0, xs[30:0]} + 32'd50;
      ov40 <= ov_x;
    end
  end

  // Stages ST_Q and ST_G: divide by one hundred
  logic [63:0] qm;
  logic [24:0] q41;
  logic [31:0] rq;
  logic [24:0] qc;
  logic [24:0] gv42;

  assign qm = 64'(xa40) * 64'(RECIP_100_Q38);
  assign rq = xa41 - 32'(32'(q41) * 32'd100);
  assign qc = q41 + 25'(rq >= 32'd100);

  always_ff @(posedge clk) begin
    if (en) begin
      q41  <= qm[62:38];
      xa41 <= xa40;
      ov41 <= ov40;
      gv42 <= (ov41 || qc > VOL_MAX) ? VOL_OVER : qc;
    end
  end

  // Stage ST_F: pick the result and saturate
  logic [24:0] vs;
  logic [25:0] res43;

  always_comb begin
    unique case (sd[ST_F-1].kind)
      KIND_GAIN: vs = gv42;
      KIND_PEAK: vs = sd[ST_F-1].peak_v;
      KIND_MIN:  vs = (sd[ST_F-1].peak_v < gv42) ? sd[ST_F-1].peak_v : gv42;
      default:   vs = 25'(1) << VOLUME_FRAC_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res43 <= {vs > VOL_MAX, sd[ST_F-1].found, (vs > VOL_MAX) ? VOL_MAX[23:0] : vs[23:0]};
    end
  end

  // Output register with one skid entry
  logic [25:0] out_res, skid_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !m_tready) begin
      if (en && v[ST_F]) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= en && v[ST_F];
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !m_tready) begin
      if (en) begin
        skid_res <= res43;
      end
    end else if (skid_v) begin
      out_res <= skid_res;
    end else begin
      out_res <= res43;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_res[23:0];
  assign m_tuser  = out_res[25:24];

  // Checks
  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 24'hFF_FFFF)
    else $error("saturated result without maximum volume");

  a_not_found_unity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == ((VOLUME_FRAC_BITS >= 24) ?
      24'hFF_FFFF : 24'(32'd1 << VOLUME_FRAC_BITS)))
    else $error("item with no field present did not give unity");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid entry filled while output register empty");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("pipeline not cleared by reset");

endmodule

// ----- rtl/core/rgv_peak_div.sv -----
// Pipelined restoring divider: 2^(FRAC_BITS+12) / peak, rounded, one bit per stage.
// Depends on rgv_pkg; instantiated by replay_gain_volume_calc.
module rgv_peak_div #(
  parameter int FRAC_BITS = rgv_pkg::VOLUME_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] peak,
  output logic [24:0] vol
);
  import rgv_pkg::*;

  localparam int NW = FRAC_BITS + 13;

  logic [NW-1:0] num [0:NW-1];
  logic [NW-1:0] quo [0:NW-1];
  logic [15:0]   rem [0:NW-1];
  logic [15:0]   dvs [0:NW-1];
  logic [NW-1:0] num_in;

  // Dividend with the rounding half added in
  assign num_in = (NW'(1) << (FRAC_BITS + 12)) + NW'(peak >> 1);

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [NW-1:0] num_i;
    logic [NW-1:0] quo_i;
    logic [15:0]   rem_i;
    logic [15:0]   dvs_i;
    logic [16:0]   rs;
    logic          ge;

    if (k == 0) begin : g_first
      assign num_i = num_in;
      assign quo_i = '0;
      assign rem_i = '0;
      assign dvs_i = peak;
    end else begin : g_next
      assign num_i = num[k-1];
      assign quo_i = quo[k-1];
      assign rem_i = rem[k-1];
      assign dvs_i = dvs[k-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    assign rs = {rem_i, num_i[NW-1-k]};
    assign ge = rs >= {1'b0, dvs_i};

    always_ff @(posedge clk) begin
      if (en) begin
        num[k] <= num_i;
        dvs[k] <= dvs_i;
        rem[k] <= ge ? 16'(rs - {1'b0, dvs_i}) : rs[15:0];
        quo[k] <= {quo_i[NW-2:0], ge};
      end
    end
  end

  // Zero peak or a quotient past the maximum both saturate
  assign vol = (dvs[NW-1] == 16'd0 || 64'(quo[NW-1]) > 64'(VOL_MAX)) ?
               VOL_OVER : 25'(quo[NW-1]);

endmodule
